### hw/rtl/atoib_pkg.sv
// atoib_pkg: shared types and constants for the text-to-integer block
// no dependencies; used by the configuration and core modules

package atoib_pkg;

    // register file geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned NSYM   = 16;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned VAL_W  = 32;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_SYM_LO = 2'd0;
    localparam logic [1:0] REG_SYM_HI = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [7:0] t_byte;

    // configuration as seen by the core
    typedef struct packed {
        t_byte [NSYM-1:0] sym;
        logic [CNT_W-1:0] count;
        logic             set_valid;
    } t_cfg;

    // whitespace test: space or codes 9 to 13
    function automatic logic is_blank(input t_byte c);
        is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

### hw/rtl/atoib_in_if.sv
// atoib_in_if: character channel, valid/ready with char_code and is_final
// depends on nothing

interface atoib_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_final;

    modport source (output valid, output char_code, output is_final, input ready);
    modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

### hw/rtl/atoib_out_if.sv
// atoib_out_if: result channel, valid/ready with the signed value
// depends on nothing

interface atoib_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/atoib_cfg.sv
// atoib_cfg: APB register file for the digit set and radix, plus the
// registered digit-set validity check; depends on atoib_pkg

module atoib_cfg #(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [atoib_pkg::ADDR_W-1:0]       paddr,
    input  logic [atoib_pkg::DATA_W-1:0]       pwdata,
    output logic [atoib_pkg::DATA_W-1:0]       prdata,
    output logic                               pready,
    output atoib_pkg::t_cfg                    o_cfg
);

    logic [atoib_pkg::DATA_W-1:0] r_sym_lo;
    logic [atoib_pkg::DATA_W-1:0] r_sym_hi;
    logic [atoib_pkg::CNT_W-1:0]  r_count;
    logic                         r_set_valid;
    logic                         n_set_valid;
    logic                         wr_en;
    logic [1:0]                   reg_idx;
    atoib_pkg::t_byte [atoib_pkg::NSYM-1:0] sym;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    assign sym     = {r_sym_hi, r_sym_lo};

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo    <= '0;
            r_sym_hi    <= '0;
            r_count     <= '0;
            r_set_valid <= 1'b0;
        end else begin
            r_set_valid <= n_set_valid;
            if (wr_en) begin
                unique case (reg_idx)
                    atoib_pkg::REG_SYM_LO: r_sym_lo <= pwdata;
                    atoib_pkg::REG_SYM_HI: r_sym_hi <= pwdata;
                    atoib_pkg::REG_COUNT:  r_count  <= pwdata[atoib_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            atoib_pkg::REG_SYM_LO: prdata = r_sym_lo;
            atoib_pkg::REG_SYM_HI: prdata = r_sym_hi;
            atoib_pkg::REG_COUNT:  prdata = {{(atoib_pkg::DATA_W-atoib_pkg::CNT_W){1'b0}}, r_count};
            default:               prdata = '0;
        endcase
    end

    // digit set check: radix range, no reserved symbol, no repeats
    always_comb begin
        n_set_valid = (r_count >= atoib_pkg::CNT_W'(2)) &&
                      (r_count <= atoib_pkg::CNT_W'(MAX_SYMBOLS));
        for (int i = 0; i < atoib_pkg::NSYM; i++) begin
            if (atoib_pkg::CNT_W'(i) < r_count) begin
                if ((sym[i] == atoib_pkg::CHAR_NUL) || (sym[i] == atoib_pkg::CHAR_PLUS) ||
                    (sym[i] == atoib_pkg::CHAR_MINUS) || atoib_pkg::is_blank(sym[i])) begin
                    n_set_valid = 1'b0;
                end
                for (int j = i + 1; j < atoib_pkg::NSYM; j++) begin
                    if ((atoib_pkg::CNT_W'(j) < r_count) && (sym[j] == sym[i])) begin
                        n_set_valid = 1'b0;
                    end
                end
            end
        end
    end

    assign o_cfg.sym       = sym;
    assign o_cfg.count     = r_count;
    assign o_cfg.set_valid = r_set_valid;

endmodule

### hw/rtl/atoib_core.sv
// atoib_core: input register, combinational parse step and result register
// depends on atoib_pkg, atoib_in_if and atoib_out_if

module atoib_core #(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atoib_pkg::t_cfg i_cfg,
    atoib_in_if.sink        i_in,
    atoib_out_if.source     o_out
);

    localparam int unsigned DIG_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic                            r_neg, n_neg;
    logic                            r_bad, n_bad;
    logic [atoib_pkg::VAL_W-1:0]     r_acc, n_acc;
    logic                            r_in_vld;
    atoib_pkg::t_byte                r_char;
    logic                            r_final;
    logic                            r_out_vld;
    logic [atoib_pkg::VAL_W-1:0]     r_value;
    logic [atoib_pkg::VAL_W-1:0]     n_value;

    logic                            advance;
    logic                            in_acc;
    logic [atoib_pkg::CNT_W-1:0]     used;
    logic                            hit;
    logic [DIG_W-1:0]                digit;

    // handshake: the input register drains unless it holds a final character while a result is blocked
    assign advance     = r_in_vld && (!r_final || !r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || advance;
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.value = r_value;

    assign used = (i_cfg.count > atoib_pkg::CNT_W'(MAX_SYMBOLS)) ?
                  atoib_pkg::CNT_W'(MAX_SYMBOLS) : i_cfg.count;

    // parallel symbol compare, lowest matching position wins
    always_comb begin
        hit   = 1'b0;
        digit = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((atoib_pkg::CNT_W'(i) < used) && (i_cfg.sym[i] == r_char) &&
                (r_char != atoib_pkg::CHAR_NUL)) begin
                hit   = 1'b1;
                digit = DIG_W'(i);
            end
        end
    end

    // one character step: whitespace, signs, then Horner accumulate
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_bad   = r_bad;
        if ((n_phase == PH_SKIP) && !atoib_pkg::is_blank(r_char)) begin
            n_phase = PH_SIGN;
        end
        if (n_phase == PH_SIGN) begin
            if (r_char == atoib_pkg::CHAR_MINUS) begin
                n_neg = !n_neg;
            end else if (r_char != atoib_pkg::CHAR_PLUS) begin
                n_phase = PH_DIGITS;
            end
        end
        if (n_phase == PH_DIGITS) begin
            if (!hit) begin
                n_bad = 1'b1;
            end else begin
                n_acc = atoib_pkg::VAL_W'(r_acc * atoib_pkg::VAL_W'(used)) +
                        atoib_pkg::VAL_W'(digit);
            end
        end
        if (n_bad || !i_cfg.set_valid) begin
            n_value = '0;
        end else if (n_neg) begin
            n_value = atoib_pkg::VAL_W'(0) - n_acc;
        end else begin
            n_value = n_acc;
        end
    end

    // state, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_bad     <= 1'b0;
            r_acc     <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
                r_char   <= i_in.char_code;
                r_final  <= i_in.is_final;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                if (r_final) begin
                    r_phase <= PH_SKIP;
                    r_neg   <= 1'b0;
                    r_bad   <= 1'b0;
                    r_acc   <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_bad   <= n_bad;
                    r_acc   <= n_acc;
                end
            end

            if (advance && r_final) begin
                r_out_vld <= 1'b1;
                r_value   <= n_value;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/text_to_integer_any_base_unit.sv
// text_to_integer_any_base_unit: top level of the text-to-integer converter
// depends on atoib_pkg, atoib_in_if, atoib_out_if, atoib_cfg and atoib_core

// Parses a string, one character per transaction, into a signed 32-bit value
// in a programmable radix of 2 to MAX_SYMBOLS, with the digit symbols held in
// two 64-bit registers and the radix in a third. One character is taken every
// clock cycle unless a final character waits on a blocked result; the symbol
// compare and accumulator multiply-add are combinational, allowing that rate.
// A final character passes the input register, then the result register that
// holds the string's result. While a result waits, the characters of the next
// string keep entering until its final character reaches the input register,
// which then holds the input until the waiting result is taken. The digit set
// check is registered, so a write takes effect for validity in the next cycle.

module text_to_integer_any_base_unit #(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    atoib_in_if.sink                      i_in,
    atoib_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [atoib_pkg::ADDR_W-1:0]  paddr,
    input  logic [atoib_pkg::DATA_W-1:0]  pwdata,
    output logic [atoib_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    atoib_pkg::t_cfg cfg;

    // configuration registers
    atoib_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // parse datapath
    atoib_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/atoib_chk.sv
// atoib_chk: port-level checks on the text-to-integer converter
// bound to text_to_integer_any_base_unit; no package dependency

module atoib_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_is_final,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed or dropped");

    // a new result comes from an earlier final character, through the input and result registers
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_is_final, 2))
        else $error("result without a final character");

    // with no result pending the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind text_to_integer_any_base_unit atoib_chk u_atoib_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_is_final (i_in.is_final),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.value)
);

### tb/sv/atoib_checker.sv
// atoib_checker: predicts the parsed value of every string and checks the results
// depends on atoib_pkg, atoib_in_if and atoib_out_if

module atoib_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    atoib_in_if                          i_chars,
    atoib_out_if                         i_values,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [atoib_pkg::ADDR_W-1:0] paddr,
    input  logic [atoib_pkg::DATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SCAN_BLANKS = 2'd0,
        SCAN_SIGNS  = 2'd1,
        SCAN_DIGITS = 2'd2
    } t_scan;

    // per-string parse state
    t_scan                              scan;
    logic                               minus;
    logic [atoib_pkg::VAL_W-1:0]        acc;
    logic                               stray;

    // register copies
    logic [atoib_pkg::NSYM-1:0][7:0]    digit_sym;
    logic [atoib_pkg::CNT_W-1:0]        radix_reg;

    logic signed [atoib_pkg::VAL_W-1:0] expected_values[$];
    int                                 fails;

    function automatic logic blank_code(input atoib_pkg::t_byte c);
        return (c == atoib_pkg::CHAR_SPACE) ||
               (c >= atoib_pkg::CHAR_TAB && c <= atoib_pkg::CHAR_CR);
    endfunction

    function automatic logic [31:0] radix_in_use();
        return (radix_reg < atoib_pkg::NSYM) ? 32'(radix_reg) : 32'(atoib_pkg::NSYM);
    endfunction

    // position of c among the symbols in use
    function automatic logic digit_value(input atoib_pkg::t_byte c, output logic [31:0] d);
        d = '0;
        if (c == atoib_pkg::CHAR_NUL) return 1'b0;
        for (int i = 0; i < radix_in_use(); i++) begin
            if (digit_sym[i] == c) begin
                d = 32'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // radix in range, symbols unique, no sign, blank or nul among them
    function automatic logic digit_set_ok();
        if (radix_reg < 2 || radix_reg > atoib_pkg::NSYM) return 1'b0;
        for (int i = 0; i < radix_reg; i++) begin
            if (digit_sym[i] == atoib_pkg::CHAR_NUL || digit_sym[i] == atoib_pkg::CHAR_PLUS ||
                digit_sym[i] == atoib_pkg::CHAR_MINUS || blank_code(digit_sym[i]))
                return 1'b0;
            for (int j = i + 1; j < radix_reg; j++)
                if (digit_sym[j] == digit_sym[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_string();
        scan  = SCAN_BLANKS;
        minus = 1'b0;
        acc   = '0;
        stray = 1'b0;
    endfunction

    // one character through the parser, queues the value on the final one
    function automatic void parse_char(input atoib_pkg::t_byte c, input logic fin);
        logic [31:0]                        d;
        logic signed [atoib_pkg::VAL_W-1:0] v;
        if (scan == SCAN_BLANKS && !blank_code(c)) scan = SCAN_SIGNS;
        if (scan == SCAN_SIGNS) begin
            if (c == atoib_pkg::CHAR_MINUS) minus = !minus;
            else if (c != atoib_pkg::CHAR_PLUS) scan = SCAN_DIGITS;
        end
        if (scan == SCAN_DIGITS) begin
            if (digit_value(c, d)) acc = acc * radix_in_use() + d;
            else stray = 1'b1;
        end
        if (fin) begin
            v = '0;
            if (!stray && digit_set_ok()) v = minus ? 32'(32'd0 - acc) : acc;
            expected_values.push_back(v);
            clear_string();
        end
    endfunction

    // watch configuration, characters and results at every edge
    always @(posedge i_clk) begin : watch
        logic signed [atoib_pkg::VAL_W-1:0] want;
        if (!i_rst_n) begin
            clear_string();
            digit_sym = '0;
            radix_reg = '0;
            expected_values.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    atoib_pkg::REG_SYM_LO: digit_sym[7:0]  = pwdata;
                    atoib_pkg::REG_SYM_HI: digit_sym[15:8] = pwdata;
                    atoib_pkg::REG_COUNT:  radix_reg       = pwdata[atoib_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_chars.valid && i_chars.ready)
                parse_char(i_chars.char_code, i_chars.is_final);
            if (i_values.valid && i_values.ready) begin
                if (expected_values.size() == 0) begin
                    $display("%0t: result %0d (0x%08h) with no value expected",
                             $time, i_values.value, i_values.value);
                    fails++;
                end else begin
                    want = expected_values.pop_front();
                    if (i_values.value !== want) begin
                        $display("%0t: value mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                                 $time, want, want, i_values.value, i_values.value);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= expected_values.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/tb_top.sv
// tb_top: drives strings and register settings into the text-to-integer unit
// depends on atoib_pkg, the channel interfaces, the unit and atoib_checker

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RANDOM_ITEMS = 1100;
    localparam int    PHASE_ITEMS  = 110;
    localparam int    SETTLE       = 8;
    localparam int    LONG_HOLD    = 300;
    localparam string HEX_DIGITS   = "0123456789abcdef";
    localparam string DEC_DIGITS   = "0123456789";

    typedef enum int {
        FLAW_REPEAT,
        FLAW_SIGN,
        FLAW_BLANK,
        FLAW_NUL,
        FLAW_COUNT
    } t_flaw;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [atoib_pkg::ADDR_W-1:0] paddr;
    logic [atoib_pkg::DATA_W-1:0] pwdata;
    logic [atoib_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    int                           fail_count;
    int                           pending;

    atoib_in_if  chars ();
    atoib_out_if results ();

    // stimulus-side copy of the digit set, used to build strings
    logic [15:0][7:0]  cur_syms;
    int                cur_count;
    int                burst_left;
    bit                steady_feed;
    bit                squeeze_req;
    int                random_items;

    text_to_integer_any_base_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars),
        .o_out   (results),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    atoib_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chars      (chars),
        .i_values     (results),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: stall patterns chosen at random, one long hold-off
    initial begin : sink_pacing
        int cycle_no;
        int hold_left;
        int mode;
        cycle_no      = 0;
        hold_left     = 0;
        mode          = 0;
        results.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (cycle_no % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                results.ready <= 1'b0;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                results.ready <= 1'b0;
            end else begin
                case (mode)
                    0: results.ready <= 1'b1;
                    1: results.ready <= 1'($urandom_range(0, 1));
                    2: results.ready <= (cycle_no % 4 == 0);
                    default: results.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic atoib_pkg::t_byte any_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? atoib_pkg::CHAR_SPACE : atoib_pkg::t_byte'(atoib_pkg::CHAR_TAB + k);
    endfunction

    function automatic atoib_pkg::t_byte any_sign();
        return $urandom_range(0, 1) ? atoib_pkg::CHAR_MINUS : atoib_pkg::CHAR_PLUS;
    endfunction

    function automatic atoib_pkg::t_byte any_digit(input int n_used);
        if (n_used > 0) return cur_syms[$urandom_range(0, n_used - 1)];
        return atoib_pkg::t_byte'($urandom_range(1, 255));
    endfunction

    function automatic logic fit_symbol(input atoib_pkg::t_byte b);
        return b != atoib_pkg::CHAR_NUL && b != atoib_pkg::CHAR_PLUS &&
               b != atoib_pkg::CHAR_MINUS && !atoib_pkg::is_blank(b);
    endfunction

    function automatic logic [63:0] digits_word(input string s, input int base);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (base + i < s.len()) w[8*i +: 8] = s[base + i];
        return w;
    endfunction

    // n distinct legal symbols, unused slots filled with any byte
    function automatic logic [127:0] random_digit_set(input int n);
        logic [15:0][7:0] set;
        logic [255:0]     taken;
        atoib_pkg::t_byte b;
        taken = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < n) begin
                do b = atoib_pkg::t_byte'($urandom_range(1, 255));
                while (taken[b] || !fit_symbol(b));
                taken[b] = 1'b1;
                set[i]   = b;
            end else begin
                set[i] = atoib_pkg::t_byte'($urandom_range(0, 255));
            end
        end
        return set;
    endfunction

    // one character, with bursts and gaps on the sending side
    task automatic offer_char(input atoib_pkg::t_byte c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap        = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                chars.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.is_final  <= fin;
        @(posedge i_clk);
        while (!chars.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_char(atoib_pkg::t_byte'(s[i]), i == s.len() - 1);
    endtask

    // stop sending, wait for every expected value, then let the pipeline settle
    task automatic wait_drained();
        chars.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup then access, then back to idle
    task automatic reg_write(input logic [1:0] idx, input logic [atoib_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_digits(input logic [63:0] lo, input logic [63:0] hi, input int cnt);
        wait_drained();
        reg_write(atoib_pkg::REG_SYM_LO, lo);
        reg_write(atoib_pkg::REG_SYM_HI, hi);
        reg_write(atoib_pkg::REG_COUNT, 64'(cnt));
        cur_syms  = {hi, lo};
        cur_count = cnt;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random digit set, optionally broken in one way
    task automatic program_random(input logic flawed);
        logic [15:0][7:0] set;
        int               n;
        int               i;
        int               j;
        t_flaw            flaw;
        n   = $urandom_range(2, 16);
        set = random_digit_set(n);
        if (flawed) begin
            flaw = t_flaw'($urandom_range(0, 4));
            i    = $urandom_range(0, n - 1);
            case (flaw)
                FLAW_REPEAT: begin
                    j      = (i + $urandom_range(1, n - 1)) % n;
                    set[j] = set[i];
                end
                FLAW_SIGN:  set[i] = any_sign();
                FLAW_BLANK: set[i] = any_blank();
                FLAW_NUL:   set[i] = atoib_pkg::CHAR_NUL;
                default:    n = $urandom_range(0, 1);
            endcase
        end
        program_digits(set[7:0], set[15:8], n);
    endtask

    // mostly well-formed strings, some with stray characters or misplaced signs
    task automatic send_random_string();
        atoib_pkg::t_byte text[$];
        int               kind;
        int               n_used;
        int               len;
        n_used = (cur_count < 16) ? cur_count : 16;
        kind   = $urandom_range(0, 99);
        repeat ($urandom_range(0, 3)) text.push_back(any_blank());
        repeat ($urandom_range(0, 3)) text.push_back(any_sign());
        if (kind < 92) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            repeat (len) text.push_back(any_digit(n_used));
        end
        if (kind >= 80 && kind < 87)
            text[$urandom_range(0, text.size() - 1)] = atoib_pkg::t_byte'($urandom_range(1, 255));
        if (kind >= 87 && kind < 92) begin
            text.push_back(any_sign());
            text.push_back(any_digit(n_used));
        end
        if (kind >= 96) begin
            text.delete();
            repeat ($urandom_range(1, 4))
                text.push_back(atoib_pkg::t_byte'($urandom_range(1, 255)));
        end
        if (text.size() == 0) text.push_back(any_blank());
        foreach (text[i]) offer_char(text[i], i == text.size() - 1);
        random_items += text.size();
    endtask

    initial begin : stimulus
        int phase_no;
        int phase_stop;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.is_final  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cur_syms        = '0;
        cur_count       = 0;
        burst_left      = 0;
        steady_feed     = 1'b0;
        squeeze_req     = 1'b0;
        random_items    = 0;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset digit set is empty, so any string gives zero
        send_text("7");

        // hex set: blanks at both ends of the range, sign run, most negative value
        program_digits(digits_word(HEX_DIGITS, 0), digits_word(HEX_DIGITS, 8), 16);
        send_text("\011\015 -+-1f");
        send_text("-80000000");
        send_text("-");
        send_text("1g");

        // radix changed in the middle of a string
        offer_char("1", 1'b0);
        program_digits(digits_word(HEX_DIGITS, 0), digits_word(HEX_DIGITS, 8), 2);
        send_text("1");

        // broken digit sets: repeated symbol, sign, blank, nul, single symbol
        program_digits('1, '1, 2);
        send_text("\377");
        program_digits(digits_word("0+", 0), '0, 2);
        send_text("0");
        program_digits(digits_word("0 ", 0), '0, 2);
        send_text("0");
        program_digits(64'h0030, '0, 2);
        send_text("0");
        program_digits(digits_word("0", 0), '0, 1);
        send_text("0");

        // random phases, each under its own digit set
        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase_no)
                0: program_digits(digits_word(HEX_DIGITS, 0), digits_word(HEX_DIGITS, 8), 16);
                1: program_digits(digits_word("01", 0), '0, 2);
                2: program_digits(digits_word(DEC_DIGITS, 0), digits_word(DEC_DIGITS, 8), 10);
                3: program_random(1'b0);
                4: program_random(1'b1);
                default: program_random($urandom_range(0, 3) == 0);
            endcase
            steady_feed = (phase_no == 3) || ($urandom_range(0, 3) == 0);
            if (phase_no == 3) squeeze_req = 1'b1;
            phase_stop = random_items + PHASE_ITEMS;
            while (random_items < phase_stop) send_random_string();
            phase_no++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### text_to_integer_any_base_unit.f
hw/rtl/atoib_pkg.sv
hw/rtl/atoib_in_if.sv
hw/rtl/atoib_out_if.sv
hw/rtl/atoib_cfg.sv
hw/rtl/atoib_core.sv
hw/rtl/text_to_integer_any_base_unit.sv
hw/rtl/atoib_chk.sv
tb/sv/atoib_checker.sv
tb/sv/tb_top.sv
